@@ rtl/gcnl_pkg.sv @@
// gcnl_pkg: word types, constants and saturation helper for the
// gaussian copy-number log-likelihood accumulator
// no dependencies
package gcnl_pkg;

	localparam int SAMPLES = 64;
	localparam int LEVELS = 10;
	localparam int ADDR_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int ACC_W = 48;
	localparam int ENTRY_W = ACC_W + 1;

	localparam logic [23:0] LN2_Q24 = 24'd11629080;
	localparam int LL_BIAS_Q8 = -1894;

	localparam logic signed [53:0] ACC_MAX54 = (54'sd1 <<< 47) - 54'sd1;
	localparam logic signed [53:0] ACC_MIN54 = -(54'sd1 <<< 47);
	localparam logic signed [47:0] ACC_MAX48 = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] ACC_MIN48 = {1'b1, {47{1'b0}}};

	typedef struct packed {
		logic [5:0]  sample;
		logic [23:0] coverage;
		logic [23:0] mean;
		logic [23:0] variance;
		logic [3:0]  copies;
		logic [15:0] site_factor;
		logic [15:0] mismap;
		logic        restart;
		logic        last;
	} site_t;

	typedef struct packed {
		logic [5:0]         out_sample;
		logic signed [47:0] total_ll;
		logic               bad_variance;
	} result_t;

	function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
		logic signed [47:0] r;
		if (v > ACC_MAX54) begin
			r = ACC_MAX48;
		end else if (v < ACC_MIN54) begin
			r = ACC_MIN48;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/gcnl_ram.sv @@
// gcnl_ram: generic single write port, single read port ram
// registered read data; no dependencies
module gcnl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]        wdata,
	input  logic                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/gaussian_copy_number_loglik_accum_top.sv @@
// gaussian_copy_number_loglik_accum_top: per-sample gaussian log-likelihood
// accumulator built around one shared multiplier and a sequencer
// depends on gcnl_pkg and gcnl_ram
//
//  port      dir  handshake                  word
//  site      in   site_valid / site_ready    gcnl_pkg::site_t
//  result    out  result_valid / result_ready gcnl_pkg::result_t
//
// from accept to the next site_ready: 5 product steps, 6 normalize steps, 16 log
// squaring steps through the shared 32x32 multiplier, 50 restoring divide steps,
// 5 other steps and idle, plus the output state with a sum word; zero variance jumps
// to accumulate, a saturated quotient skips the divide; site_ready only in idle
// a full output register holds the sequencer at its last step until result_ready
// per-sample valid bits are cleared by reset, so no clearing pass is needed
module gaussian_copy_number_loglik_accum_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              site_valid,
	output logic              site_ready,
	input  gcnl_pkg::site_t   site,
	output logic              result_valid,
	input  logic              result_ready,
	output gcnl_pkg::result_t result
);
	import gcnl_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCALE = 4'd1;
	localparam logic [3:0] ST_MU    = 4'd2;
	localparam logic [3:0] ST_VAR   = 4'd3;
	localparam logic [3:0] ST_DIFF  = 4'd4;
	localparam logic [3:0] ST_SQ    = 4'd5;
	localparam logic [3:0] ST_NORM  = 4'd6;
	localparam logic [3:0] ST_LOGI  = 4'd7;
	localparam logic [3:0] ST_LOG   = 4'd8;
	localparam logic [3:0] ST_HL    = 4'd9;
	localparam logic [3:0] ST_DIVI  = 4'd10;
	localparam logic [3:0] ST_DIV   = 4'd11;
	localparam logic [3:0] ST_LL    = 4'd12;
	localparam logic [3:0] ST_ACC   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	localparam logic signed [53:0] BIAS54 = 54'(LL_BIAS_Q8);

	logic [3:0]         state_q;
	logic [5:0]         cnt_q;
	logic [SAMPLES-1:0] vld_q;
	logic               out_valid_q;
	result_t            out_q;

	site_t              item_q;
	logic [19:0]        cnsf_q;
	logic [22:0]        scale_q;
	logic [46:0]        mu_q;
	logic [46:0]        var_q;
	logic [31:0]        a8_q;
	logic [62:0]        num_q;
	logic [46:0]        norm_q;
	logic [5:0]         lz_q;
	logic [5:0]         e_q;
	logic [30:0]        m_q;
	logic [15:0]        frac_q;
	logic [13:0]        hl_q;
	logic [49:0]        dvd_q;
	logic [46:0]        rem_q;
	logic [49:0]        quo_q;
	logic               qsat_q;
	logic signed [47:0] ll_q;
	logic               bad_q;
	result_t            res_q;

	logic               accept;
	logic               in_range;
	logic [3:0]         cn_clamp;
	site_t              site_c;
	logic [ADDR_W-1:0]  idx;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [22:0]        scale_c;
	logic [46:0]        x24;
	logic [46:0]        adiff;
	logic [47:0]        around;
	logic [5:0]         amt;
	logic [5:0]         sh;
	logic               top_zero;
	logic [31:0]        sq_t;
	logic [46:0]        hl_sum;
	logic               div_sat;
	logic [47:0]        div_r;
	logic               div_ge;
	logic [50:0]        quad;
	logic signed [53:0] tot;
	logic               clr;
	logic [ENTRY_W-1:0] rd_entry;
	logic signed [47:0] old_sum;
	logic               old_bad;
	logic signed [47:0] new_sum;
	logic               new_bad;
	logic               ram_we;
	logic               out_load;

	assign site_ready = (state_q == ST_IDLE);
	assign accept = site_valid && site_ready;
	assign in_range = (int'(site.sample) < SAMPLES);
	assign cn_clamp = (int'(site.copies) >= LEVELS) ? 4'(LEVELS - 1) : site.copies;
	assign idx = item_q.sample[ADDR_W-1:0];

	always_comb begin
		site_c = site;
		site_c.copies = cn_clamp;
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SCALE: begin
				mul_a = {28'd0, item_q.copies};
				mul_b = {16'd0, item_q.site_factor};
			end
			ST_MU: begin
				mul_a = {8'd0, item_q.mean};
				mul_b = {9'd0, scale_c};
			end
			ST_VAR: begin
				mul_a = {8'd0, item_q.variance};
				mul_b = {9'd0, scale_q};
			end
			ST_SQ: begin
				mul_a = a8_q;
				mul_b = a8_q;
			end
			ST_LOG: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			ST_HL: begin
				mul_a = {10'd0, e_q, frac_q};
				mul_b = {8'd0, LN2_Q24};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign scale_c = {1'b0, cnsf_q, 2'b00} + {7'd0, item_q.mismap};
	assign x24 = {7'd0, item_q.coverage, 16'd0};
	assign adiff = (x24 >= mu_q) ? (x24 - mu_q) : (mu_q - x24);
	assign around = {1'b0, adiff} + 48'd32768;

	assign amt = 6'd32 >> cnt_q[2:0];
	assign sh = 6'd47 - amt;
	assign top_zero = ((norm_q >> sh) == 47'd0);

	assign sq_t = mul_p[61:30];
	assign hl_sum = mul_p[46:0] + (47'd1 << 32);

	assign div_sat = ({19'd0, num_q} >= {var_q, 35'd0});
	assign div_r = {rem_q, dvd_q[49]};
	assign div_ge = (div_r >= {1'b0, var_q});

	assign quad = qsat_q ? (51'd1 << 50) : {1'b0, quo_q};
	assign tot = $signed({3'd0, quad}) + $signed({40'd0, hl_q}) + BIAS54;

	assign clr = item_q.restart || !vld_q[idx];
	assign old_sum = clr ? 48'sd0 : $signed(rd_entry[ACC_W-1:0]);
	assign old_bad = clr ? 1'b0 : rd_entry[ACC_W];
	assign new_sum = sat48(54'(old_sum) + 54'(ll_q));
	assign new_bad = old_bad | bad_q;
	assign ram_we = (state_q == ST_ACC);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || result_ready);

	gcnl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SAMPLES)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx),
		.wdata({new_bad, new_sum}),
		.re   (accept),
		.raddr(site.sample[ADDR_W-1:0]),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_range) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_MU;
				ST_MU:    state_q <= ST_VAR;
				ST_VAR:   state_q <= ST_DIFF;
				ST_DIFF: begin
					state_q <= (var_q == 47'd0) ? ST_ACC : ST_SQ;
				end
				ST_SQ: begin
					cnt_q <= '0;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (cnt_q == 6'd5) begin
						state_q <= ST_LOGI;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				ST_LOGI: begin
					cnt_q <= 6'd15;
					state_q <= ST_LOG;
				end
				ST_LOG: begin
					if (cnt_q == 6'd0) begin
						state_q <= ST_HL;
					end
					cnt_q <= cnt_q - 6'd1;
				end
				ST_HL: state_q <= ST_DIVI;
				ST_DIVI: begin
					cnt_q <= 6'd49;
					state_q <= div_sat ? ST_LL : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 6'd0) begin
						state_q <= ST_LL;
					end
					cnt_q <= cnt_q - 6'd1;
				end
				ST_LL: state_q <= ST_ACC;
				ST_ACC: begin
					vld_q[idx] <= 1'b1;
					state_q <= item_q.last ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= site_c;
			bad_q <= 1'b0;
		end
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_SCALE: cnsf_q <= mul_p[19:0];
			ST_MU: begin
				scale_q <= scale_c;
				mu_q <= mul_p[46:0];
			end
			ST_VAR: var_q <= mul_p[46:0];
			ST_DIFF: begin
				a8_q <= around[47:16];
				norm_q <= var_q;
				lz_q <= '0;
				if (var_q == 47'd0) begin
					bad_q <= 1'b1;
					ll_q <= ACC_MIN48;
				end
			end
			ST_SQ: num_q <= mul_p[62:0];
			ST_NORM: begin
				if (top_zero) begin
					norm_q <= norm_q << amt;
					lz_q <= lz_q + amt;
				end
			end
			ST_LOGI: begin
				m_q <= norm_q[46:16];
				e_q <= 6'd46 - lz_q;
				frac_q <= '0;
			end
			ST_LOG: begin
				if (sq_t[31]) begin
					m_q <= sq_t[31:1];
					frac_q[cnt_q[3:0]] <= 1'b1;
				end else begin
					m_q <= sq_t[30:0];
				end
			end
			ST_HL: hl_q <= hl_sum[46:33];
			ST_DIVI: begin
				qsat_q <= div_sat;
				rem_q <= {19'd0, num_q[62:35]};
				dvd_q <= {num_q[34:0], 15'd0};
			end
			ST_DIV: begin
				rem_q <= div_ge ? 47'(div_r - {1'b0, var_q}) : div_r[46:0];
				quo_q <= {quo_q[48:0], div_ge};
				dvd_q <= dvd_q << 1;
			end
			ST_LL: ll_q <= sat48(-tot);
			ST_ACC: begin
				res_q.out_sample <= item_q.sample;
				res_q.total_ll <= new_sum;
				res_q.bad_variance <= new_bad;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	// normalized mantissa and divider invariants
	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOGI) |-> norm_q[46])
		else $error("variance not normalized before log");
	a_mant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOG) |-> m_q[30])
		else $error("log mantissa left [1,2)");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < var_q))
		else $error("divider remainder not below divisor");
	a_zero_var: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && bad_q) |-> (ll_q == ACC_MIN48))
		else $error("zero variance site without floor term");
endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for gaussian_copy_number_loglik_accum_top
// drives site words, predicts per-sample log-likelihood sums and checks result words
// depends on gcnl_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;
	import gcnl_pkg::*;

	localparam int N_RANDOM = 700;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic site_valid = 1'b0;
	logic site_ready;
	site_t site = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	logic signed [47:0] acc_sum [SAMPLES];
	logic acc_bad [SAMPLES];
	result_t expected_sums [$];
	int errors = 0;
	longint cycles = 0;
	bit stim_done = 1'b0;
	bit quiet = 1'b0;
	bit hold_off = 1'b0;

	gaussian_copy_number_loglik_accum_top uut (
		.clk(clk), .arst_n(arst_n),
		.site_valid(site_valid), .site_ready(site_ready), .site(site),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic logic [63:0] div_half(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] r;
		logic [63:0] q;
		logic bitv;
		bit sat;
		r = 0;
		q = 0;
		sat = 0;
		for (int i = 77; i >= 0; i--) begin
			bitv = (i >= 15) ? num[i - 15] : 1'b0;
			r = {r[62:0], bitv};
			if (r >= den) begin
				r = r - den;
				if (i >= 50) sat = 1;
				else q[i] = 1'b1;
			end
		end
		return sat ? (64'd1 << 50) : q;
	endfunction

	function automatic logic [63:0] log2_fix(input logic [63:0] v);
		int e;
		logic [63:0] m;
		logic [63:0] frac;
		e = 0;
		frac = 0;
		while (e < 63 && (v >> (e + 1)) != 0) e++;
		m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac[k] = 1'b1;
			end
		end
		return (64'(e) << 16) + frac;
	endfunction

	function automatic logic signed [47:0] clip48(input logic signed [63:0] v);
		if (v > 64'sd140737488355327) return {1'b0, {47{1'b1}}};
		if (v < -64'sd140737488355328) return {1'b1, {47{1'b0}}};
		return v[47:0];
	endfunction

	// update the per-sample sums; returns 1 when a sum word is due
	function automatic bit site_loglik(input site_t w, output result_t r);
		logic [63:0] cn, scale, mu, vr, x24, a, a8, quad, hl;
		logic signed [63:0] ll, tot;
		int s;
		s = w.sample;
		r = '0;
		if (s >= SAMPLES) return 0;
		cn = (int'(w.copies) >= LEVELS) ? 64'(LEVELS - 1) : 64'(w.copies);
		scale = ((cn * w.site_factor) << 2) + w.mismap;
		mu = w.mean * scale;
		vr = w.variance * scale;
		if (w.restart) begin
			acc_sum[s] = 0;
			acc_bad[s] = 0;
		end
		if (vr == 0) begin
			acc_bad[s] = 1;
			ll = -64'sd140737488355328;
		end else begin
			x24 = 64'(w.coverage) << 16;
			a = (x24 >= mu) ? x24 - mu : mu - x24;
			a8 = (a + (64'd1 << 15)) >> 16;
			quad = div_half(a8 * a8, vr);
			hl = (log2_fix(vr) * 64'(LN2_Q24) + (64'd1 << 32)) >> 33;
			tot = $signed(quad) + $signed(hl) + 64'(LL_BIAS_Q8);
			ll = clip48(-tot);
		end
		acc_sum[s] = clip48(64'(acc_sum[s]) + ll);
		if (!w.last) return 0;
		r.out_sample = s[5:0];
		r.total_ll = acc_sum[s];
		r.bad_variance = acc_bad[s];
		return 1;
	endfunction

	task automatic idle_sender();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			site_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_site(input site_t w, input bit check_sum, input logic signed [47:0] sum_want,
			input bit bad_want);
		result_t r;
		if (site_loglik(w, r)) begin
			if (check_sum && (r.total_ll !== sum_want || r.bad_variance !== bad_want))
				report($sformatf("predictor disagrees with table row, sample %0d", w.sample));
			expected_sums.push_back(r);
		end
		site_valid <= 1'b1;
		site <= w;
		@(posedge clk);
		while (!site_ready) @(posedge clk);
		idle_sender();
	endtask

	function automatic site_t rand_site(input int sample_hi);
		site_t w;
		w.sample = 6'($urandom_range(0, sample_hi));
		w.mean = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 20000));
		w.coverage = ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
			24'(w.mean * $urandom_range(0, 4) + $urandom_range(0, 4000));
		w.variance = ($urandom_range(0, 9) == 0) ? 24'd0 :
			(($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(1, 40000)));
		w.copies = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15)) :
			4'($urandom_range(0, 9));
		w.site_factor = 16'($urandom());
		w.mismap = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
		w.restart = ($urandom_range(0, 15) == 0);
		w.last = ($urandom_range(0, 5) == 0);
		return w;
	endfunction

	typedef struct {
		site_t w;
		bit check_sum;
		logic signed [47:0] sum_want;
		bit bad_want;
	} row_t;

	function automatic site_t mk(input logic [5:0] s, input logic [23:0] x, m, v,
			input logic [3:0] c, input logic [15:0] f, mm, input bit rs, l);
		site_t w;
		w = '{s, x, m, v, c, f, mm, rs, l};
		return w;
	endfunction

	row_t rows [$];

	initial begin
		site_t w;
		rows.push_back('{mk(6'd0, 24'd0, 24'd0, 24'd0, 4'd0, 16'd0, 16'd0, 1'b0, 1'b1), 1'b1,
			{1'b1, {47{1'b0}}}, 1'b1});
		rows.push_back('{mk(6'd0, 24'hFFFFFF, 24'd0, 24'd0, 4'd9, 16'hFFFF, 16'd0, 1'b0, 1'b1),
			1'b1, {1'b1, {47{1'b0}}}, 1'b1});
		rows.push_back('{mk(6'd63, 24'd256, 24'd256, 24'd256, 4'd1, 16'd16384, 16'd0, 1'b1, 1'b0),
			1'b0, '0, 1'b0});
		rows.push_back('{mk(6'd63, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'd15, 16'hFFFF, 16'hFFFF,
			1'b0, 1'b1), 1'b0, '0, 1'b0});
		rows.push_back('{mk(6'd1, 24'hFFFFFF, 24'd0, 24'd1, 4'd0, 16'd0, 16'd1, 1'b1, 1'b1),
			1'b0, '0, 1'b0});
		rows.push_back('{mk(6'd1, 24'd0, 24'hFFFFFF, 24'd1, 4'd12, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1),
			1'b0, '0, 1'b0});
		rows.push_back('{mk(6'd2, 24'd5000, 24'd1000, 24'd500, 4'd10, 16'h2000, 16'h8000, 1'b1,
			1'b1), 1'b0, '0, 1'b0});
		rows.push_back('{mk(6'd2, 24'd100, 24'd100, 24'd0, 4'd3, 16'h4000, 16'h0100, 1'b0, 1'b1),
			1'b1, {1'b1, {47{1'b0}}}, 1'b1});
		rows.push_back('{mk(6'd0, 24'd0, 24'd0, 24'd0, 4'd0, 16'd0, 16'd0, 1'b0, 1'b1), 1'b1,
			{1'b1, {47{1'b0}}}, 1'b1});
		rows.push_back('{mk(6'd0, 24'd512, 24'd256, 24'd1024, 4'd2, 16'h4000, 16'd0, 1'b1, 1'b1),
			1'b0, '0, 1'b0});
		rows.push_back('{mk(6'd42, 24'hAAAAAA, 24'h555555, 24'h5A5A5A, 4'd5, 16'hA5A5, 16'h5A5A,
			1'b0, 1'b0), 1'b0, '0, 1'b0});
		rows.push_back('{mk(6'd42, 24'h555555, 24'hAAAAAA, 24'hA5A5A5, 4'd8, 16'h5A5A, 16'hA5A5,
			1'b0, 1'b1), 1'b0, '0, 1'b0});

		for (int i = 0; i < SAMPLES; i++) begin
			acc_sum[i] = 0;
			acc_bad[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_site(rows[i].w, rows[i].check_sum, rows[i].sum_want, rows[i].bad_want);

		// fill the block while the result side is held off
		hold_off = 1'b1;
		for (int i = 0; i < 6; i++) begin
			w = rand_site(3);
			w.last = 1'b1;
			send_site(w, 1'b0, '0, 1'b0);
		end
		hold_off = 1'b0;

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 120) quiet = 1'b1;
			w = rand_site(i % 50 < 25 ? 3 : 63);
			send_site(w, 1'b0, '0, 1'b0);
		end
		site_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		result_t want;
		int gap;
		int hold;
		wait (arst_n);
		hold = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				if (expected_sums.size() == 0) begin
					report("sum word with none expected");
				end else begin
					want = expected_sums.pop_front();
					if (result.out_sample !== want.out_sample)
						report($sformatf("out_sample %0d want %0d", result.out_sample,
							want.out_sample));
					if (result.total_ll !== want.total_ll)
						report($sformatf("total_ll %0d want %0d", result.total_ll, want.total_ll));
					if (result.bad_variance !== want.bad_variance)
						report($sformatf("bad_variance %0b want %0b", result.bad_variance,
							want.bad_variance));
				end
			end
			if (hold_off && hold == 0) hold = 1;
			if (hold > 0 && hold < 600) begin
				hold++;
				result_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 19);
				result_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (stim_done);
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
